// ----- design/limit_order_book_matcher_macros.svh -----
// Assertion macros shared by the order book matcher RTL.
// Depends on a clock named clock and an active high reset named reset in scope.
`ifndef LIMIT_ORDER_BOOK_MATCHER_MACROS_SVH
`define LIMIT_ORDER_BOOK_MATCHER_MACROS_SVH

// Checked property, ignored while reset is high.
`define OBM_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked property that also holds during reset.
`define OBM_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- design/obm_pkg.sv -----
// Package for the order book matcher: sizes, codes and shared structs.
// Used by obm_book, obm_ctrl and the top level; depends on nothing.
`timescale 1ns / 1ps

package obm_pkg;

   localparam int BOOK_SLOTS = 32;
   localparam int IDX_W = $clog2(BOOK_SLOTS);
   localparam int CNT_W = $clog2(BOOK_SLOTS + 1);

   localparam logic [31:0] SEQ_MAX = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      ACT_NEW,
      ACT_CANCEL,
      ACT_REDUCE,
      ACT_REPLACE
   } act_type;

   typedef enum logic [1:0] {
      TR_GTC,
      TR_IOC,
      TR_FOK,
      TR_POST
   } tr_type;

   localparam logic [2:0] EV_ACCEPTED  = 3'd0;
   localparam logic [2:0] EV_REJECTED  = 3'd1;
   localparam logic [2:0] EV_TRADE     = 3'd2;
   localparam logic [2:0] EV_RESTED    = 3'd3;
   localparam logic [2:0] EV_EXPIRED   = 3'd4;
   localparam logic [2:0] EV_CANCELLED = 3'd5;
   localparam logic [2:0] EV_REDUCED   = 3'd6;
   localparam logic [2:0] EV_REPLACED  = 3'd7;

   localparam logic [3:0] CAUSE_DUPLICATE = 4'd0;
   localparam logic [3:0] CAUSE_ZERO      = 4'd1;
   localparam logic [3:0] CAUSE_PRICE     = 4'd2;
   localparam logic [3:0] CAUSE_TYPE      = 4'd3;
   localparam logic [3:0] CAUSE_FILL      = 4'd4;
   localparam logic [3:0] CAUSE_CROSS     = 4'd5;
   localparam logic [3:0] CAUSE_OVERFLOW  = 4'd6;
   localparam logic [3:0] CAUSE_SEQUENCE  = 4'd7;
   localparam logic [3:0] CAUSE_UNKNOWN   = 4'd8;
   localparam logic [3:0] CAUSE_REDUCTION = 4'd9;
   localparam logic [3:0] CAUSE_FULL      = 4'd10;
   localparam logic [3:0] CAUSE_MARKET    = 4'd11;
   localparam logic [3:0] CAUSE_IOC       = 4'd12;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_FIND,
      ST_ACT,
      ST_VSCAN,
      ST_DECIDE,
      ST_BEST,
      ST_TRADE,
      ST_AFTER,
      ST_FREE,
      ST_REST
   } st_type;

   // One slot as read from the book.
   typedef struct packed {
      logic              valid;
      logic              buy;
      logic signed [31:0] price;
      logic [31:0]       qty;
      logic [31:0]       id;
      logic [31:0]       prio;
   } slot_type;

   // Access to the book: one address for both read and write.
   typedef struct packed {
      logic [IDX_W-1:0]  addr;
      logic              put;
      logic              set_qty;
      logic              clear;
      logic              buy;
      logic signed [31:0] price;
      logic [31:0]       qty;
      logic [31:0]       id;
      logic [31:0]       prio;
   } bk_cmd_type;

   typedef struct packed {
      logic [2:0]        kind;
      logic [31:0]       number;
      logic [31:0]       subject;
      logic [31:0]       maker;
      logic signed [31:0] price;
      logic [31:0]       qty;
      logic signed [31:0] pprice;
      logic [31:0]       pqty;
      logic [3:0]        cause;
      logic              aggr;
      logic              kept;
      logic              last;
   } ev_type;

endpackage

// ----- design/obm_if.sv -----
// Handshake channels of the order book matcher: command words in, event words out.
// Stand-alone; no package dependency.
`timescale 1ns / 1ps

interface obm_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        action;
   logic [31:0]       order_tag;
   logic              buy_side;
   logic              is_market;
   logic [1:0]        time_rule;
   logic              price_present;
   logic signed [31:0] order_price;
   logic [31:0]       order_quantity;
   logic [31:0]       reduce_amount;

   modport source (output valid, action, order_tag, buy_side, is_market, time_rule,
                   price_present, order_price, order_quantity, reduce_amount,
                   input ready);
   modport sink (input valid, action, order_tag, buy_side, is_market, time_rule,
                 price_present, order_price, order_quantity, reduce_amount,
                 output ready);
endinterface

interface obm_rsp_if;
   logic              valid;
   logic              ready;
   logic [2:0]        event_kind;
   logic [31:0]       event_number;
   logic [31:0]       subject_id;
   logic [31:0]       maker_id;
   logic signed [31:0] event_price;
   logic [31:0]       event_quantity;
   logic signed [31:0] prior_price;
   logic [31:0]       prior_quantity;
   logic [3:0]        cause;
   logic              aggressor_buy;
   logic              kept_priority;
   logic              last_event;

   modport source (output valid, event_kind, event_number, subject_id, maker_id,
                   event_price, event_quantity, prior_price, prior_quantity, cause,
                   aggressor_buy, kept_priority, last_event, input ready);
   modport sink (input valid, event_kind, event_number, subject_id, maker_id,
                 event_price, event_quantity, prior_price, prior_quantity, cause,
                 aggressor_buy, kept_priority, last_event, output ready);
endinterface

// ----- design/obm_book.sv -----
// Resting order table: flip-flop slots with one read/write address per cycle.
// Depends on obm_pkg.
`timescale 1ns / 1ps

module obm_book (
   input  logic               clock,
   input  logic               reset,
   input  obm_pkg::bk_cmd_type cmd,
   output obm_pkg::slot_type  rd
);
   import obm_pkg::*;

   logic [BOOK_SLOTS-1:0] valid_ff, valid_in;
   logic                  buy_ff   [BOOK_SLOTS];
   logic signed [31:0]    price_ff [BOOK_SLOTS];
   logic [31:0]           qty_ff   [BOOK_SLOTS];
   logic [31:0]           id_ff    [BOOK_SLOTS];
   logic [31:0]           prio_ff  [BOOK_SLOTS];

   always_comb begin
      valid_in = valid_ff;
      if (cmd.put) begin
         valid_in[cmd.addr] = 1'b1;
      end else if (cmd.clear) begin
         valid_in[cmd.addr] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.put) begin
         buy_ff[cmd.addr]   <= cmd.buy;
         price_ff[cmd.addr] <= cmd.price;
         id_ff[cmd.addr]    <= cmd.id;
         prio_ff[cmd.addr]  <= cmd.prio;
      end
      if (cmd.put || cmd.set_qty) begin
         qty_ff[cmd.addr] <= cmd.qty;
      end
   end

   assign rd.valid = valid_ff[cmd.addr];
   assign rd.buy   = buy_ff[cmd.addr];
   assign rd.price = price_ff[cmd.addr];
   assign rd.qty   = qty_ff[cmd.addr];
   assign rd.id    = id_ff[cmd.addr];
   assign rd.prio  = prio_ff[cmd.addr];

endmodule

// ----- design/obm_ctrl.sv -----
// Command sequencer: walks the book one slot a cycle for lookup, validation,
// best-price search and free-slot search, then emits event words.
// Depends on obm_pkg, obm_if and the assertion macros.
`timescale 1ns / 1ps
`include "limit_order_book_matcher_macros.svh"

module obm_ctrl (
   input  logic                clock,
   input  logic                reset,
   obm_req_if.sink             req_port,
   input  logic                out_free,
   output logic                emit,
   output obm_pkg::ev_type     ev,
   output obm_pkg::bk_cmd_type cmd,
   input  obm_pkg::slot_type   rd
);
   import obm_pkg::*;

   localparam logic [32:0] SAT33 = {1'b1, 32'h0};

   st_type             state_ff, state_in;
   act_type            act_ff, act_in;
   tr_type             tif_ff, tif_in;
   logic [31:0]        id_ff, id_in, qty_ff, qty_in, red_ff, red_in;
   logic               buy_ff, buy_in, mkt_ff, mkt_in, hp_ff, hp_in;
   logic signed [31:0] price_ff, price_in, op_ff, op_in, bprice_ff, bprice_in;
   logic [31:0]        oq_ff, oq_in, bprio_ff, bprio_in, rem_ff, rem_in;
   logic               rep_ff, rep_in, found_ff, found_in, dup_ff, dup_in;
   logic               have_ff, have_in, hfree_ff, hfree_in;
   logic [IDX_W-1:0]   idx_ff, idx_in, fidx_ff, fidx_in, best_ff, best_in;
   logic [IDX_W-1:0]   free_ff, free_in;
   logic [32:0]        cq_ff, cq_in, lvl_ff, lvl_in;
   logic [CNT_W-1:0]   ccnt_ff, ccnt_in, fcnt_ff, fcnt_in;
   logic [31:0]        ectr_ff, ectr_in, pctr_ff, pctr_in;

   logic               last_idx, crosses, better, rest_ok, reject;
   logic [33:0]        cq_sum, lvl_sum;
   logic [31:0]        exec_q, rest_q, trade_q;
   logic [3:0]         cause_v;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ectr_ff  <= '0;
         pctr_ff  <= '0;
      end else begin
         state_ff <= state_in;
         ectr_ff  <= ectr_in;
         pctr_ff  <= pctr_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff <= act_in;     tif_ff <= tif_in;     id_ff <= id_in;
      qty_ff <= qty_in;     red_ff <= red_in;     buy_ff <= buy_in;
      mkt_ff <= mkt_in;     hp_ff <= hp_in;       price_ff <= price_in;
      op_ff <= op_in;       oq_ff <= oq_in;       bprice_ff <= bprice_in;
      bprio_ff <= bprio_in; rem_ff <= rem_in;     rep_ff <= rep_in;
      found_ff <= found_in; dup_ff <= dup_in;     have_ff <= have_in;
      hfree_ff <= hfree_in; idx_ff <= idx_in;     fidx_ff <= fidx_in;
      best_ff <= best_in;   free_ff <= free_in;   cq_ff <= cq_in;
      lvl_ff <= lvl_in;     ccnt_ff <= ccnt_in;   fcnt_ff <= fcnt_in;
   end

   // Per-slot datapath: last_idx ends every scan; the compares serve validation and best-price search.
   assign last_idx = (idx_ff == IDX_W'(BOOK_SLOTS - 1));
   assign crosses  = rd.valid && (rd.buy != buy_ff) &&
                     (mkt_ff || (buy_ff ? (rd.price <= price_ff) : (rd.price >= price_ff)));
   assign better   = !have_ff ||
                     ((rd.price != bprice_ff) ?
                      (buy_ff ? (rd.price < bprice_ff) : (rd.price > bprice_ff)) :
                      (rd.prio < bprio_ff));
   assign cq_sum   = {1'b0, cq_ff} + {2'b00, rd.qty};
   assign exec_q   = ({1'b0, qty_ff} > cq_ff) ? cq_ff[31:0] : qty_ff;
   assign rest_q   = (!mkt_ff && hp_ff && tif_ff != TR_IOC && tif_ff != TR_FOK) ?
                     (qty_ff - exec_q) : 32'd0;
   assign lvl_sum  = {1'b0, lvl_ff} + {2'b00, rest_q};
   assign trade_q  = (rem_ff < rd.qty) ? rem_ff : rd.qty;
   assign rest_ok  = rep_ff || (!mkt_ff && (tif_ff == TR_GTC || tif_ff == TR_POST));

   // Validation order: first failing check wins.
   always_comb begin
      reject  = 1'b1;
      cause_v = CAUSE_DUPLICATE;
      if (dup_ff && !rep_ff) begin
         cause_v = CAUSE_DUPLICATE;
      end else if (qty_ff == 32'd0) begin
         cause_v = CAUSE_ZERO;
      end else if (!mkt_ff && (!hp_ff || price_ff <= 32'sd0)) begin
         cause_v = CAUSE_PRICE;
      end else if (mkt_ff && hp_ff) begin
         cause_v = CAUSE_PRICE;
      end else if (mkt_ff && tif_ff != TR_IOC && tif_ff != TR_FOK) begin
         cause_v = CAUSE_TYPE;
      end else if (tif_ff == TR_FOK && exec_q < qty_ff) begin
         cause_v = CAUSE_FILL;
      end else if (tif_ff == TR_POST && ccnt_ff != '0) begin
         cause_v = CAUSE_CROSS;
      end else if (rest_q != 32'd0 && (|lvl_sum[33:32])) begin
         cause_v = CAUSE_OVERFLOW;
      end else if (rest_q != 32'd0 && pctr_ff == SEQ_MAX) begin
         cause_v = CAUSE_SEQUENCE;
      end else if (rest_q != 32'd0 && fcnt_ff == '0 && ccnt_ff == '0 && !rep_ff) begin
         cause_v = CAUSE_FULL;
      end else begin
         reject = 1'b0;
      end
   end

   always_comb begin
      state_in = state_ff;  act_in = act_ff;     tif_in = tif_ff;
      id_in = id_ff;        qty_in = qty_ff;     red_in = red_ff;
      buy_in = buy_ff;      mkt_in = mkt_ff;     hp_in = hp_ff;
      price_in = price_ff;  op_in = op_ff;       oq_in = oq_ff;
      bprice_in = bprice_ff; bprio_in = bprio_ff; rem_in = rem_ff;
      rep_in = rep_ff;      found_in = found_ff; dup_in = dup_ff;
      have_in = have_ff;    hfree_in = hfree_ff; idx_in = idx_ff;
      fidx_in = fidx_ff;    best_in = best_ff;   free_in = free_ff;
      cq_in = cq_ff;        lvl_in = lvl_ff;     ccnt_in = ccnt_ff;
      fcnt_in = fcnt_ff;    pctr_in = pctr_ff;

      req_port.ready = (state_ff == ST_IDLE);
      emit = 1'b0;
      ev = '0;
      ev.number = ectr_ff;
      ev.subject = id_ff;

      cmd = '0;
      case (state_ff)
         ST_ACT, ST_DECIDE: cmd.addr = fidx_ff;
         ST_TRADE:          cmd.addr = best_ff;
         ST_REST:           cmd.addr = free_ff;
         default:           cmd.addr = idx_ff;
      endcase

      case (state_ff)
         ST_IDLE: begin
            if (req_port.valid) begin
               act_in   = act_type'(req_port.action);
               id_in    = req_port.order_tag;
               buy_in   = req_port.buy_side;
               mkt_in   = req_port.is_market;
               tif_in   = tr_type'(req_port.time_rule);
               hp_in    = req_port.price_present;
               price_in = req_port.order_price;
               qty_in   = req_port.order_quantity;
               red_in   = req_port.reduce_amount;
               state_in = ST_START;
            end
         end
         ST_START: begin
            idx_in   = '0;
            found_in = 1'b0;
            dup_in   = 1'b0;
            rep_in   = 1'b0;
            cq_in    = '0;
            lvl_in   = '0;
            ccnt_in  = '0;
            fcnt_in  = '0;
            if (ectr_ff == SEQ_MAX) begin
               if (out_free) begin
                  emit = 1'b1;
                  ev.kind = EV_REJECTED;
                  ev.cause = CAUSE_SEQUENCE;
                  ev.last = 1'b1;
                  state_in = ST_IDLE;
               end
            end else if (act_ff == ACT_NEW) begin
               state_in = ST_VSCAN;
            end else begin
               state_in = ST_FIND;
            end
         end
         ST_FIND: begin
            if (rd.valid && rd.id == id_ff && !found_ff) begin
               found_in = 1'b1;
               fidx_in  = idx_ff;
            end
            idx_in = idx_ff + 1'b1;
            if (last_idx) begin
               state_in = ST_ACT;
            end
         end
         ST_ACT: begin
            if (out_free) begin
               ev.last = 1'b1;
               state_in = ST_IDLE;
               if (!found_ff) begin
                  emit = 1'b1;
                  ev.kind = EV_REJECTED;
                  ev.cause = CAUSE_UNKNOWN;
               end else if (act_ff == ACT_CANCEL) begin
                  cmd.clear = 1'b1;
                  emit = 1'b1;
                  ev.kind = EV_CANCELLED;
                  ev.qty = rd.qty;
               end else if (act_ff == ACT_REDUCE) begin
                  emit = 1'b1;
                  if (red_ff == 32'd0 || red_ff >= rd.qty) begin
                     ev.kind = EV_REJECTED;
                     ev.cause = CAUSE_REDUCTION;
                  end else begin
                     cmd.set_qty = 1'b1;
                     cmd.qty = rd.qty - red_ff;
                     ev.kind = EV_REDUCED;
                     ev.qty = rd.qty - red_ff;
                     ev.pqty = rd.qty;
                  end
               end else if (qty_ff == 32'd0) begin
                  emit = 1'b1;
                  ev.kind = EV_REJECTED;
                  ev.cause = CAUSE_ZERO;
               end else if (price_ff <= 32'sd0) begin
                  emit = 1'b1;
                  ev.kind = EV_REJECTED;
                  ev.cause = CAUSE_PRICE;
               end else if (price_ff == rd.price && qty_ff <= rd.qty) begin
                  cmd.set_qty = 1'b1;
                  cmd.qty = qty_ff;
                  emit = 1'b1;
                  ev.kind = EV_REPLACED;
                  ev.price = price_ff;
                  ev.qty = qty_ff;
                  ev.pprice = rd.price;
                  ev.pqty = rd.qty;
                  ev.kept = 1'b1;
               end else begin
                  // Moved replace: revalidate as a plain limit order on its own side.
                  ev.last = 1'b0;
                  buy_in = rd.buy;
                  mkt_in = 1'b0;
                  tif_in = TR_GTC;
                  hp_in = 1'b1;
                  op_in = rd.price;
                  oq_in = rd.qty;
                  rep_in = 1'b1;
                  idx_in = '0;
                  state_in = ST_VSCAN;
               end
            end
         end
         ST_VSCAN: begin
            if (!rd.valid) begin
               fcnt_in = fcnt_ff + 1'b1;
            end else begin
               if (crosses) begin
                  cq_in = (|cq_sum[33:32]) ? SAT33 : cq_sum[32:0];
                  ccnt_in = ccnt_ff + 1'b1;
               end
               if (!(rep_ff && idx_ff == fidx_ff) && rd.buy == buy_ff &&
                   rd.price == price_ff) begin
                  lvl_in = (|(({1'b0, lvl_ff} + {2'b00, rd.qty}) >> 32)) ? SAT33 :
                           33'({1'b0, lvl_ff} + {2'b00, rd.qty});
               end
               if (rd.id == id_ff) begin
                  dup_in = 1'b1;
               end
            end
            idx_in = idx_ff + 1'b1;
            if (last_idx) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (out_free) begin
               emit = 1'b1;
               idx_in = '0;
               have_in = 1'b0;
               rem_in = qty_ff;
               if (reject) begin
                  ev.kind = EV_REJECTED;
                  ev.cause = cause_v;
                  ev.last = 1'b1;
                  state_in = ST_IDLE;
               end else if (rep_ff) begin
                  cmd.clear = 1'b1;
                  ev.kind = EV_REPLACED;
                  ev.price = price_ff;
                  ev.qty = qty_ff;
                  ev.pprice = op_ff;
                  ev.pqty = oq_ff;
                  state_in = ST_BEST;
               end else begin
                  ev.kind = EV_ACCEPTED;
                  ev.qty = qty_ff;
                  state_in = (tif_ff == TR_POST) ? ST_AFTER : ST_BEST;
               end
            end
         end
         ST_BEST: begin
            if (crosses && better) begin
               have_in = 1'b1;
               best_in = idx_ff;
               bprice_in = rd.price;
               bprio_in = rd.prio;
            end
            idx_in = idx_ff + 1'b1;
            if (last_idx) begin
               state_in = have_in ? ST_TRADE : ST_AFTER;
            end
         end
         ST_TRADE: begin
            if (out_free) begin
               cmd.set_qty = 1'b1;
               cmd.qty = rd.qty - trade_q;
               cmd.clear = (rd.qty == trade_q);
               emit = 1'b1;
               ev.kind = EV_TRADE;
               ev.maker = rd.id;
               ev.price = rd.price;
               ev.qty = trade_q;
               ev.aggr = buy_ff;
               ev.last = (rem_ff == trade_q);
               rem_in = rem_ff - trade_q;
               idx_in = '0;
               have_in = 1'b0;
               state_in = (rem_ff == trade_q) ? ST_IDLE : ST_BEST;
            end
         end
         ST_AFTER: begin
            if (rest_ok) begin
               idx_in = '0;
               hfree_in = 1'b0;
               state_in = ST_FREE;
            end else if (out_free) begin
               emit = 1'b1;
               ev.kind = EV_EXPIRED;
               ev.qty = rem_ff;
               ev.cause = mkt_ff ? CAUSE_MARKET : CAUSE_IOC;
               ev.last = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_FREE: begin
            if (!rd.valid && !hfree_ff) begin
               hfree_in = 1'b1;
               free_in = idx_ff;
            end
            idx_in = idx_ff + 1'b1;
            if (last_idx) begin
               state_in = ST_REST;
            end
         end
         ST_REST: begin
            if (out_free) begin
               cmd.put = 1'b1;
               cmd.buy = buy_ff;
               cmd.price = price_ff;
               cmd.qty = rem_ff;
               cmd.id = id_ff;
               cmd.prio = pctr_ff;
               if (pctr_ff != SEQ_MAX) begin
                  pctr_in = pctr_ff + 32'd1;
               end
               emit = 1'b1;
               ev.kind = EV_RESTED;
               ev.price = price_ff;
               ev.qty = rem_ff;
               ev.last = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      ectr_in = (emit && ectr_ff != SEQ_MAX) ? ectr_ff + 32'd1 : ectr_ff;
   end

   `OBM_ASSERT(a_busy_after_accept, req_port.valid && req_port.ready |=> !req_port.ready, "busy")
   `OBM_ASSERT(a_trade_has_rem, state_ff == ST_TRADE |-> rem_ff != 32'd0, "empty trade")
   `OBM_ASSERT(a_last_ends_run, emit && ev.last |=> state_ff == ST_IDLE, "run not ended")
   `OBM_ASSERT(a_counter_monotonic, !$past(reset) |-> ectr_ff >= $past(ectr_ff), "counter fell")

endmodule

// ----- design/limit_order_book_matcher.sv -----
// Top level of the order book matcher: sequencer, order table and output register.
// Depends on obm_pkg, obm_if, obm_book and obm_ctrl.
`timescale 1ns / 1ps

// Price-time priority matcher over a 32-slot table of resting orders. Each command word
// is taken when req_port is ready, which is only between commands; its events leave
// one at a time through a single output register on rsp_port, the last marked by
// last_event. The sequencer visits one table slot per cycle: a cancel or reduce makes
// one id lookup pass, a new order a validation pass plus one best-price pass per
// trade, one more pass if nothing is left to cross, and a free-slot pass before
// resting; a moved replace adds the lookup pass. Each event waits while the
// event consumer stalls. The table needs no clearing after reset.
module limit_order_book_matcher (
   input logic     clock,
   input logic     reset,
   obm_req_if.sink req_port,
   obm_rsp_if.source rsp_port
);
   import obm_pkg::*;

   logic       emit, out_free;
   ev_type     ev;
   bk_cmd_type cmd;
   slot_type   rd;
   logic       out_valid_ff, out_valid_in;
   ev_type     out_ff, out_in;

   obm_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_port),
      .out_free (out_free),
      .emit     (emit),
      .ev       (ev),
      .cmd      (cmd),
      .rd       (rd)
   );

   obm_book u_book (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .rd    (rd)
   );

   assign out_free = !out_valid_ff || rsp_port.ready;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in = out_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_in = ev;
      end else if (rsp_port.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_port.valid          = out_valid_ff;
   assign rsp_port.event_kind     = out_ff.kind;
   assign rsp_port.event_number   = out_ff.number;
   assign rsp_port.subject_id     = out_ff.subject;
   assign rsp_port.maker_id       = out_ff.maker;
   assign rsp_port.event_price    = out_ff.price;
   assign rsp_port.event_quantity = out_ff.qty;
   assign rsp_port.prior_price    = out_ff.pprice;
   assign rsp_port.prior_quantity = out_ff.pqty;
   assign rsp_port.cause          = out_ff.cause;
   assign rsp_port.aggressor_buy  = out_ff.aggr;
   assign rsp_port.kept_priority  = out_ff.kept;
   assign rsp_port.last_event     = out_ff.last;

endmodule
